// ===== hw/rtl/openpgp_signature_packet_parser_defines.svh =====
// assertion macros shared by the signature packet parser checkers
// no dependencies; pulled in by `include where assertions are written
`ifndef OPENPGP_SIGNATURE_PACKET_PARSER_DEFINES_SVH
`define OPENPGP_SIGNATURE_PACKET_PARSER_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define OPGP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("opgp assertion failed");

// next-cycle implication, masked while reset is asserted
`define OPGP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("opgp assertion failed");

// next-cycle implication that also watches the reset itself
`define OPGP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("opgp assertion failed");

`endif

// ===== hw/rtl/opgp_pkg.sv =====
// types and codes of the signature packet parser
// no dependencies; used by opgp_in_stage, opgp_parse and the top level through opgp_pkg:: names
`timescale 1ns / 1ps

package opgp_pkg;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_NEWLEN  = 5'd1,
    PH_NEWLEN2 = 5'd2,
    PH_MULTI   = 5'd3,
    PH_VER     = 5'd4,
    PH_TYPE    = 5'd5,
    PH_PK      = 5'd6,
    PH_HASH    = 5'd7,
    PH_HLEN    = 5'd8,
    PH_HDATA   = 5'd9,
    PH_ULEN    = 5'd10,
    PH_UDATA   = 5'd11,
    PH_PREFIX  = 5'd12,
    PH_MPILEN  = 5'd13,
    PH_MPI     = 5'd14,
    PH_EXCESS  = 5'd15,
    PH_SKIP    = 5'd16,
    PH_AFTER   = 5'd17,
    PH_ERR     = 5'd18
  } phase_t;

  // byte roles
  localparam logic [3:0] ROLE_HDR      = 4'd0;
  localparam logic [3:0] ROLE_LEN      = 4'd1;
  localparam logic [3:0] ROLE_VER      = 4'd2;
  localparam logic [3:0] ROLE_TYPE     = 4'd3;
  localparam logic [3:0] ROLE_PKALGO   = 4'd4;
  localparam logic [3:0] ROLE_HASHALGO = 4'd5;
  localparam logic [3:0] ROLE_HLEN     = 4'd6;
  localparam logic [3:0] ROLE_HDATA    = 4'd7;
  localparam logic [3:0] ROLE_ULEN     = 4'd8;
  localparam logic [3:0] ROLE_UDATA    = 4'd9;
  localparam logic [3:0] ROLE_PREFIX   = 4'd10;
  localparam logic [3:0] ROLE_MPILEN   = 4'd11;
  localparam logic [3:0] ROLE_MPI      = 4'd12;
  localparam logic [3:0] ROLE_EXCESS   = 4'd13;
  localparam logic [3:0] ROLE_IGNORED  = 4'd14;
  localparam logic [3:0] ROLE_AFTERERR = 4'd15;

  // status codes
  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_SHORT_HDR    = 4'd1;
  localparam logic [3:0] ST_BAD_HDR      = 4'd2;
  localparam logic [3:0] ST_PARTIAL_LEN  = 4'd3;
  localparam logic [3:0] ST_INDET_LEN    = 4'd4;
  localparam logic [3:0] ST_BODY_EXCEEDS = 4'd5;
  localparam logic [3:0] ST_NOT_SIG      = 4'd6;
  localparam logic [3:0] ST_BODY_SMALL   = 4'd7;
  localparam logic [3:0] ST_BAD_VERSION  = 4'd8;
  localparam logic [3:0] ST_HASHED_LONG  = 4'd9;
  localparam logic [3:0] ST_NO_ULEN      = 4'd10;
  localparam logic [3:0] ST_UNHASHED_LONG = 4'd11;
  localparam logic [3:0] ST_NO_PREFIX    = 4'd12;
  localparam logic [3:0] ST_MPI_TRUNC    = 4'd13;
  localparam logic [3:0] ST_MPI_LONG     = 4'd14;
  localparam logic [3:0] ST_EXCESS       = 4'd15;

  // header constants
  localparam logic [5:0] TAG_SIGNATURE   = 6'd2;
  localparam logic [1:0] OLD_LEN_INDET   = 2'd3;
  localparam logic [1:0] OLD_LEN_ONE     = 2'd0;
  localparam logic [1:0] OLD_LEN_TWO     = 2'd1;
  localparam logic [7:0] NEW_LEN_TWO_MIN = 8'd192;
  localparam logic [7:0] NEW_LEN_PARTIAL = 8'd224;
  localparam logic [7:0] NEW_LEN_FIVE    = 8'd255;
  localparam logic [7:0] SIG_VERSION     = 8'd4;
  localparam logic [31:0] BODY_MIN       = 32'd6;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [7:0]  out_byte;
    logic        done_res;
    logic [3:0]  status;
    logic [7:0]  signature_type;
    logic [7:0]  key_algorithm;
    logic [7:0]  digest_algorithm;
    logic [15:0] digest_prefix;
    logic [15:0] hashed_area_len;
    logic [15:0] unhashed_area_len;
    logic [15:0] mpi_bit_count;
  } result_t;

endpackage

// ===== hw/rtl/opgp_if.sv =====
// valid/ready channels of the signature packet parser
// payload fields mirror the opgp_pkg item and result types
`timescale 1ns / 1ps

interface opgp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface opgp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  byte_role;
  logic [7:0]  out_byte;
  logic        done_res;
  logic [3:0]  status;
  logic [7:0]  signature_type;
  logic [7:0]  key_algorithm;
  logic [7:0]  digest_algorithm;
  logic [15:0] digest_prefix;
  logic [15:0] hashed_area_len;
  logic [15:0] unhashed_area_len;
  logic [15:0] mpi_bit_count;

  modport source (
    output valid, output byte_role, output out_byte, output done_res, output status,
    output signature_type, output key_algorithm, output digest_algorithm,
    output digest_prefix, output hashed_area_len, output unhashed_area_len,
    output mpi_bit_count, input ready
  );
  modport sink (
    input valid, input byte_role, input out_byte, input done_res, input status,
    input signature_type, input key_algorithm, input digest_algorithm,
    input digest_prefix, input hashed_area_len, input unhashed_area_len,
    input mpi_bit_count, output ready
  );
endinterface

// ===== hw/rtl/openpgp_signature_packet_parser.sv =====
// OpenPGP v4 signature packet parser, top level
// needs opgp_pkg, opgp_if, opgp_in_stage and opgp_parse
`timescale 1ns / 1ps

// Takes a detached signature blob one byte per transfer on in_ch, with in_last
// on the final byte, and gives exactly one result per byte on out_ch. Each
// result tags the byte's role (header, length, version, type, algorithms,
// subpacket areas, hash prefix, MPI, excess, ignored, after error) and passes
// the byte through. The result for the last byte has done_res set and carries
// the status and the captured signature fields; the parser then returns to
// idle for the next blob. On other results status and the fields are zero.
// Header errors are reported at once; errors inside the body are held back
// and reported only if the blob reaches the declared body end, while a blob
// that stops short reports "body exceeds data". Bytes after the packet are
// tagged ignored and leave the status alone. Rate: one byte per clock cycle,
// sustained while neither channel stalls. The parse state is updated between
// the input register and the result register, so each byte passes through
// both registers before its result shows on out_ch. Both channels may stall
// at any time. LENGTH_COUNTER_BITS (16..32) sizes the body byte counter; a
// declared body length beyond its range saturates to all ones.

module openpgp_signature_packet_parser #(
  parameter int LENGTH_COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  opgp_in_if.sink     in_ch,
  opgp_out_if.source  out_ch
);

  logic               item_valid;
  opgp_pkg::in_item_t item;
  opgp_pkg::result_t  res;
  opgp_pkg::result_t  res_r;
  logic               out_v_r;
  logic               out_v_nxt;
  logic               step;

  // a byte is decoded when the result register is free or being emptied
  assign step = item_valid && (!out_v_r || out_ch.ready);

  // input register: lets a new byte in while a result still waits
  opgp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  // parse state machine and per-byte result
  opgp_parse #(
    .LCB (LENGTH_COUNTER_BITS)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .res   (res)
  );

  // result register
  always_comb begin
    out_v_nxt = out_v_r;
    if (step) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.byte_role         = res_r.byte_role;
  assign out_ch.out_byte          = res_r.out_byte;
  assign out_ch.done_res          = res_r.done_res;
  assign out_ch.status            = res_r.status;
  assign out_ch.signature_type    = res_r.signature_type;
  assign out_ch.key_algorithm     = res_r.key_algorithm;
  assign out_ch.digest_algorithm  = res_r.digest_algorithm;
  assign out_ch.digest_prefix     = res_r.digest_prefix;
  assign out_ch.hashed_area_len   = res_r.hashed_area_len;
  assign out_ch.unhashed_area_len = res_r.unhashed_area_len;
  assign out_ch.mpi_bit_count     = res_r.mpi_bit_count;

endmodule

// ===== hw/rtl/opgp_in_stage.sv =====
// input register of the signature packet parser
// uses opgp_in_if and opgp_pkg::in_item_t
`timescale 1ns / 1ps

module opgp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  opgp_in_if.sink           in_ch,
  input  logic              take,
  output logic              item_valid,
  output opgp_pkg::in_item_t item
);

  logic               v_r;
  logic               v_nxt;
  opgp_pkg::in_item_t item_r;
  logic               load;

  assign in_ch.ready = !v_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    v_nxt = v_r;
    if (load) begin
      v_nxt = 1'b1;
    end else if (take) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.in_byte <= in_ch.in_byte;
      item_r.in_last <= in_ch.in_last;
    end
  end

  assign item_valid = v_r;
  assign item       = item_r;

endmodule

// ===== hw/rtl/opgp_parse.sv =====
// parse state and per-byte decode of the signature packet parser
// uses opgp_pkg phases, roles, status codes and item types
`timescale 1ns / 1ps

module opgp_parse #(
  parameter int LCB = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  opgp_pkg::in_item_t item,
  output opgp_pkg::result_t  res
);

  localparam logic [32:0] LEN_CAP = (33'd1 << LCB) - 33'd1;

  opgp_pkg::phase_t phase_r, phase_nxt;
  logic [LCB-1:0]   br_r, br_nxt, br_dec;
  logic [31:0]      acc_r, acc_nxt;
  logic [15:0]      fr_r, fr_nxt;
  logic [3:0]       pend_r, pend_nxt;
  logic [5:0]       tag_r, tag_nxt;
  logic [7:0]       stype_r, stype_nxt;
  logic [7:0]       pk_r, pk_nxt;
  logic [7:0]       hash_r, hash_nxt;
  logic [15:0]      prefix_r, prefix_nxt;
  logic [15:0]      hlen_r, hlen_nxt;
  logic [15:0]      ulen_r, ulen_nxt;
  logic [15:0]      mbits_r, mbits_nxt;

  logic [7:0]       b;
  logic             in_body;
  logic             fr_last;
  logic [15:0]      acc_two;
  logic [31:0]      acc_multi;
  logic [31:0]      fin_len;
  logic [31:0]      fin_sat;
  logic [3:0]       fin_pend;
  opgp_pkg::phase_t fin_phase;
  logic [16:0]      mpi_round;
  logic [13:0]      mpi_nbytes;
  logic [3:0]       role;
  logic [3:0]       st;

  assign b         = item.in_byte;
  assign in_body   = (phase_r >= opgp_pkg::PH_VER) && (phase_r <= opgp_pkg::PH_SKIP);
  assign br_dec    = (in_body && (br_r != '0)) ? br_r - LCB'(1) : br_r;
  assign fr_last   = (fr_r <= 16'd1);
  assign acc_two   = {acc_r[7:0], b};
  assign acc_multi = {acc_r[23:0], b};
  assign mpi_round = {1'b0, acc_two} + 17'd7;
  assign mpi_nbytes = mpi_round[16:3];

  // header length source depends on which length form closes the header
  always_comb begin
    unique case (phase_r)
      opgp_pkg::PH_NEWLEN:  fin_len = {24'd0, b};
      opgp_pkg::PH_NEWLEN2: fin_len = {16'd0, acc_r[7:0], 8'd0} + {24'd0, b} + 32'd192;
      default:              fin_len = acc_multi;
    endcase
  end

  assign fin_sat = ({1'b0, fin_len} > LEN_CAP) ? LEN_CAP[31:0] : fin_len;

  always_comb begin
    if (tag_r != opgp_pkg::TAG_SIGNATURE) begin
      fin_pend = opgp_pkg::ST_NOT_SIG;
    end else if (fin_sat < opgp_pkg::BODY_MIN) begin
      fin_pend = opgp_pkg::ST_BODY_SMALL;
    end else begin
      fin_pend = pend_r;
    end
    if (fin_sat == 32'd0) begin
      fin_phase = opgp_pkg::PH_AFTER;
    end else if (fin_pend != opgp_pkg::ST_OK) begin
      fin_phase = opgp_pkg::PH_SKIP;
    end else begin
      fin_phase = opgp_pkg::PH_VER;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    br_nxt     = br_dec;
    acc_nxt    = acc_r;
    fr_nxt     = fr_r;
    pend_nxt   = pend_r;
    tag_nxt    = tag_r;
    stype_nxt  = stype_r;
    pk_nxt     = pk_r;
    hash_nxt   = hash_r;
    prefix_nxt = prefix_r;
    hlen_nxt   = hlen_r;
    ulen_nxt   = ulen_r;
    mbits_nxt  = mbits_r;
    role       = opgp_pkg::ROLE_IGNORED;

    unique case (phase_r)
      opgp_pkg::PH_IDLE: begin
        role = opgp_pkg::ROLE_HDR;
        if (!b[7]) begin
          pend_nxt  = opgp_pkg::ST_BAD_HDR;
          phase_nxt = opgp_pkg::PH_ERR;
        end else if (b[6]) begin
          tag_nxt   = b[5:0];
          phase_nxt = opgp_pkg::PH_NEWLEN;
        end else begin
          tag_nxt = {2'b00, b[5:2]};
          if (b[1:0] == opgp_pkg::OLD_LEN_INDET) begin
            pend_nxt  = opgp_pkg::ST_INDET_LEN;
            phase_nxt = opgp_pkg::PH_ERR;
          end else begin
            if (b[1:0] == opgp_pkg::OLD_LEN_ONE) begin
              fr_nxt = 16'd1;
            end else if (b[1:0] == opgp_pkg::OLD_LEN_TWO) begin
              fr_nxt = 16'd2;
            end else begin
              fr_nxt = 16'd4;
            end
            acc_nxt   = 32'd0;
            phase_nxt = opgp_pkg::PH_MULTI;
          end
        end
      end
      opgp_pkg::PH_NEWLEN: begin
        role = opgp_pkg::ROLE_LEN;
        if (b < opgp_pkg::NEW_LEN_TWO_MIN) begin
          br_nxt    = fin_sat[LCB-1:0];
          pend_nxt  = fin_pend;
          phase_nxt = fin_phase;
        end else if (b < opgp_pkg::NEW_LEN_PARTIAL) begin
          acc_nxt   = {24'd0, b - opgp_pkg::NEW_LEN_TWO_MIN};
          phase_nxt = opgp_pkg::PH_NEWLEN2;
        end else if (b == opgp_pkg::NEW_LEN_FIVE) begin
          fr_nxt    = 16'd4;
          acc_nxt   = 32'd0;
          phase_nxt = opgp_pkg::PH_MULTI;
        end else begin
          pend_nxt  = opgp_pkg::ST_PARTIAL_LEN;
          phase_nxt = opgp_pkg::PH_ERR;
        end
      end
      opgp_pkg::PH_NEWLEN2: begin
        role      = opgp_pkg::ROLE_LEN;
        br_nxt    = fin_sat[LCB-1:0];
        pend_nxt  = fin_pend;
        phase_nxt = fin_phase;
      end
      opgp_pkg::PH_MULTI: begin
        role    = opgp_pkg::ROLE_LEN;
        acc_nxt = acc_multi;
        if (fr_last) begin
          fr_nxt    = 16'd0;
          br_nxt    = fin_sat[LCB-1:0];
          pend_nxt  = fin_pend;
          phase_nxt = fin_phase;
        end else begin
          fr_nxt = fr_r - 16'd1;
        end
      end
      opgp_pkg::PH_VER: begin
        role = opgp_pkg::ROLE_VER;
        if (b != opgp_pkg::SIG_VERSION) begin
          pend_nxt  = opgp_pkg::ST_BAD_VERSION;
          phase_nxt = opgp_pkg::PH_SKIP;
        end else begin
          phase_nxt = opgp_pkg::PH_TYPE;
        end
      end
      opgp_pkg::PH_TYPE: begin
        role      = opgp_pkg::ROLE_TYPE;
        stype_nxt = b;
        phase_nxt = opgp_pkg::PH_PK;
      end
      opgp_pkg::PH_PK: begin
        role      = opgp_pkg::ROLE_PKALGO;
        pk_nxt    = b;
        phase_nxt = opgp_pkg::PH_HASH;
      end
      opgp_pkg::PH_HASH: begin
        role      = opgp_pkg::ROLE_HASHALGO;
        hash_nxt  = b;
        fr_nxt    = 16'd2;
        acc_nxt   = 32'd0;
        phase_nxt = opgp_pkg::PH_HLEN;
      end
      opgp_pkg::PH_HLEN: begin
        role    = opgp_pkg::ROLE_HLEN;
        acc_nxt = {16'd0, acc_two};
        if (fr_last) begin
          fr_nxt   = 16'd0;
          hlen_nxt = acc_two;
          if (LCB'(acc_two) > br_dec) begin
            pend_nxt  = opgp_pkg::ST_HASHED_LONG;
            phase_nxt = opgp_pkg::PH_SKIP;
          end else if (acc_two == 16'd0) begin
            // empty hashed area: straight on to the unhashed length, or fail if under two body bytes remain
            if (br_dec < LCB'(2)) begin
              pend_nxt  = opgp_pkg::ST_NO_ULEN;
              phase_nxt = opgp_pkg::PH_SKIP;
            end else begin
              fr_nxt    = 16'd2;
              acc_nxt   = 32'd0;
              phase_nxt = opgp_pkg::PH_ULEN;
            end
          end else begin
            fr_nxt    = acc_two;
            phase_nxt = opgp_pkg::PH_HDATA;
          end
        end else begin
          fr_nxt = fr_r - 16'd1;
        end
      end
      opgp_pkg::PH_HDATA: begin
        role = opgp_pkg::ROLE_HDATA;
        if (fr_last) begin
          fr_nxt = 16'd0;
          if (br_dec < LCB'(2)) begin
            pend_nxt  = opgp_pkg::ST_NO_ULEN;
            phase_nxt = opgp_pkg::PH_SKIP;
          end else begin
            fr_nxt    = 16'd2;
            acc_nxt   = 32'd0;
            phase_nxt = opgp_pkg::PH_ULEN;
          end
        end else begin
          fr_nxt = fr_r - 16'd1;
        end
      end
      opgp_pkg::PH_ULEN: begin
        role    = opgp_pkg::ROLE_ULEN;
        acc_nxt = {16'd0, acc_two};
        if (fr_last) begin
          fr_nxt   = 16'd0;
          ulen_nxt = acc_two;
          if (LCB'(acc_two) > br_dec) begin
            pend_nxt  = opgp_pkg::ST_UNHASHED_LONG;
            phase_nxt = opgp_pkg::PH_SKIP;
          end else if (acc_two == 16'd0) begin
            if (br_dec < LCB'(2)) begin
              pend_nxt  = opgp_pkg::ST_NO_PREFIX;
              phase_nxt = opgp_pkg::PH_SKIP;
            end else begin
              fr_nxt    = 16'd2;
              acc_nxt   = 32'd0;
              phase_nxt = opgp_pkg::PH_PREFIX;
            end
          end else begin
            fr_nxt    = acc_two;
            phase_nxt = opgp_pkg::PH_UDATA;
          end
        end else begin
          fr_nxt = fr_r - 16'd1;
        end
      end
      opgp_pkg::PH_UDATA: begin
        role = opgp_pkg::ROLE_UDATA;
        if (fr_last) begin
          fr_nxt = 16'd0;
          if (br_dec < LCB'(2)) begin
            pend_nxt  = opgp_pkg::ST_NO_PREFIX;
            phase_nxt = opgp_pkg::PH_SKIP;
          end else begin
            fr_nxt    = 16'd2;
            acc_nxt   = 32'd0;
            phase_nxt = opgp_pkg::PH_PREFIX;
          end
        end else begin
          fr_nxt = fr_r - 16'd1;
        end
      end
      opgp_pkg::PH_PREFIX: begin
        role    = opgp_pkg::ROLE_PREFIX;
        acc_nxt = {16'd0, acc_two};
        if (fr_last) begin
          fr_nxt     = 16'd0;
          prefix_nxt = acc_two;
          if (br_dec < LCB'(2)) begin
            pend_nxt  = opgp_pkg::ST_MPI_TRUNC;
            phase_nxt = opgp_pkg::PH_SKIP;
          end else begin
            fr_nxt    = 16'd2;
            acc_nxt   = 32'd0;
            phase_nxt = opgp_pkg::PH_MPILEN;
          end
        end else begin
          fr_nxt = fr_r - 16'd1;
        end
      end
      opgp_pkg::PH_MPILEN: begin
        role    = opgp_pkg::ROLE_MPILEN;
        acc_nxt = {16'd0, acc_two};
        if (fr_last) begin
          fr_nxt    = 16'd0;
          mbits_nxt = acc_two;
          if (LCB'(mpi_nbytes) > br_dec) begin
            pend_nxt  = opgp_pkg::ST_MPI_LONG;
            phase_nxt = opgp_pkg::PH_SKIP;
          end else if (mpi_nbytes == 14'd0) begin
            if (br_dec != '0) begin
              pend_nxt  = opgp_pkg::ST_EXCESS;
              phase_nxt = opgp_pkg::PH_EXCESS;
            end
          end else begin
            fr_nxt    = {2'b00, mpi_nbytes};
            phase_nxt = opgp_pkg::PH_MPI;
          end
        end else begin
          fr_nxt = fr_r - 16'd1;
        end
      end
      opgp_pkg::PH_MPI: begin
        role = opgp_pkg::ROLE_MPI;
        if (fr_last) begin
          fr_nxt = 16'd0;
          if (br_dec != '0) begin
            pend_nxt  = opgp_pkg::ST_EXCESS;
            phase_nxt = opgp_pkg::PH_EXCESS;
          end
        end else begin
          fr_nxt = fr_r - 16'd1;
        end
      end
      opgp_pkg::PH_EXCESS: role = opgp_pkg::ROLE_EXCESS;
      opgp_pkg::PH_SKIP:   role = opgp_pkg::ROLE_AFTERERR;
      opgp_pkg::PH_ERR:    role = opgp_pkg::ROLE_AFTERERR;
      default:             role = opgp_pkg::ROLE_IGNORED;
    endcase

    // body used up: whatever body phase we are in, the packet is over
    if ((phase_nxt >= opgp_pkg::PH_VER) && (phase_nxt <= opgp_pkg::PH_SKIP) &&
        (br_nxt == '0)) begin
      phase_nxt = opgp_pkg::PH_AFTER;
    end
  end

  always_comb begin
    if ((phase_nxt == opgp_pkg::PH_ERR) || (phase_nxt == opgp_pkg::PH_AFTER)) begin
      st = pend_nxt;
    end else if (phase_nxt <= opgp_pkg::PH_MULTI) begin
      st = opgp_pkg::ST_SHORT_HDR;
    end else begin
      st = opgp_pkg::ST_BODY_EXCEEDS;
    end
  end

  always_comb begin
    res           = '0;
    res.byte_role = role;
    res.out_byte  = b;
    res.done_res  = item.in_last;
    if (item.in_last) begin
      res.status            = st;
      res.signature_type    = stype_nxt;
      res.key_algorithm     = pk_nxt;
      res.digest_algorithm  = hash_nxt;
      res.digest_prefix     = prefix_nxt;
      res.hashed_area_len   = hlen_nxt;
      res.unhashed_area_len = ulen_nxt;
      res.mpi_bit_count     = mbits_nxt;
    end
  end

  // end of blob returns everything to the reset picture
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.in_last)) begin
      phase_r  <= opgp_pkg::PH_IDLE;
      br_r     <= '0;
      acc_r    <= '0;
      fr_r     <= '0;
      pend_r   <= opgp_pkg::ST_OK;
      tag_r    <= '0;
      stype_r  <= '0;
      pk_r     <= '0;
      hash_r   <= '0;
      prefix_r <= '0;
      hlen_r   <= '0;
      ulen_r   <= '0;
      mbits_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      br_r     <= br_nxt;
      acc_r    <= acc_nxt;
      fr_r     <= fr_nxt;
      pend_r   <= pend_nxt;
      tag_r    <= tag_nxt;
      stype_r  <= stype_nxt;
      pk_r     <= pk_nxt;
      hash_r   <= hash_nxt;
      prefix_r <= prefix_nxt;
      hlen_r   <= hlen_nxt;
      ulen_r   <= ulen_nxt;
      mbits_r  <= mbits_nxt;
    end
  end

endmodule

// ===== hw/rtl/opgp_checker.sv =====
// port-level checks of the signature packet parser, bound to the top level
// needs openpgp_signature_packet_parser_defines.svh
`timescale 1ns / 1ps
`include "openpgp_signature_packet_parser_defines.svh"

module opgp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] byte_role,
  input logic [7:0] out_byte,
  input logic       done_res,
  input logic [3:0] status
);

  // reset empties the result register
  `OPGP_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

  // input only backs up when a result is waiting
  `OPGP_ASSERT_IMP(a_stall_has_result, clk, rst_n, in_valid && !in_ready, out_valid)

  // a stalled result stays offered
  `OPGP_ASSERT_NEXT(a_out_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid)

  // and does not change under the stall
  `OPGP_ASSERT_NEXT(a_out_hold_data, clk, rst_n, out_valid && !out_ready,
    $stable(byte_role) && $stable(out_byte) && $stable(done_res) && $stable(status))

endmodule

bind openpgp_signature_packet_parser opgp_checker u_opgp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .byte_role (out_ch.byte_role),
  .out_byte  (out_ch.out_byte),
  .done_res  (out_ch.done_res),
  .status    (out_ch.status)
);

// ===== dv/tb.sv =====
// testbench for openpgp_signature_packet_parser: byte-stream stimulus and per-byte result checks
// needs opgp_pkg and the opgp_in_if / opgp_out_if interfaces from the rtl
`timescale 1ns / 1ps

module tb;
  import opgp_pkg::*;

  localparam int LEN_BITS = 32;

  logic clk;
  logic rst_n;

  opgp_in_if  in_ch ();
  opgp_out_if out_ch ();

  openpgp_signature_packet_parser #(
    .LENGTH_COUNTER_BITS(LEN_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // byte stream waiting to be driven and results still owed by the parser
  in_item_t pending_bytes[$];
  result_t  expected_results[$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned bytes_queued;
  bit          in_fired;

  // parser state as the blob is walked
  phase_t      pp_phase;
  logic [31:0] pp_body_left;
  logic [31:0] pp_acc;
  logic [15:0] pp_field_left;
  logic [3:0]  pp_err;
  logic [7:0]  pp_tag;
  logic [7:0]  pp_sig_type;
  logic [7:0]  pp_key_alg;
  logic [7:0]  pp_dig_alg;
  logic [15:0] pp_prefix;
  logic [15:0] pp_hlen;
  logic [15:0] pp_ulen;
  logic [15:0] pp_mpi_bits;

  always #6 clk = ~clk;

  function automatic void clear_parser();
    pp_phase      = PH_IDLE;
    pp_body_left  = '0;
    pp_acc        = '0;
    pp_field_left = '0;
    pp_err        = ST_OK;
    pp_tag        = '0;
    pp_sig_type   = '0;
    pp_key_alg    = '0;
    pp_dig_alg    = '0;
    pp_prefix     = '0;
    pp_hlen       = '0;
    pp_ulen       = '0;
    pp_mpi_bits   = '0;
  endfunction

  function automatic void body_fail(logic [3:0] code);
    pp_err   = code;
    pp_phase = PH_SKIP;
  endfunction

  function automatic void start_pair(phase_t nxt);
    pp_phase      = nxt;
    pp_field_left = 16'd2;
    pp_acc        = '0;
  endfunction

  // declared body length is known: decide between walking the body and skipping it
  function automatic void close_header(logic [31:0] len);
    logic [63:0] cap;
    cap = (64'd1 << LEN_BITS) - 64'd1;
    if ({32'd0, len} > cap) len = cap[31:0];
    pp_body_left = len;
    if (pp_tag != {2'b00, TAG_SIGNATURE}) pp_err = ST_NOT_SIG;
    else if (len < BODY_MIN) pp_err = ST_BODY_SMALL;
    if (len == 32'd0) pp_phase = PH_AFTER;
    else if (pp_err != ST_OK) pp_phase = PH_SKIP;
    else pp_phase = PH_VER;
  endfunction

  // count down a multi-byte field, true on its final byte
  function automatic bit take_count();
    if (pp_field_left <= 16'd1) begin
      pp_field_left = '0;
      return 1'b1;
    end
    pp_field_left--;
    return 1'b0;
  endfunction

  function automatic bit take_pair(logic [7:0] b);
    pp_acc = ((pp_acc << 8) | {24'd0, b}) & 32'h0000_ffff;
    return take_count();
  endfunction

  function automatic void after_hashed();
    if (pp_body_left < 32'd2) body_fail(ST_NO_ULEN);
    else start_pair(PH_ULEN);
  endfunction

  function automatic void after_unhashed();
    if (pp_body_left < 32'd2) body_fail(ST_NO_PREFIX);
    else start_pair(PH_PREFIX);
  endfunction

  function automatic void after_mpi();
    if (pp_body_left != 32'd0) begin
      pp_err   = ST_EXCESS;
      pp_phase = PH_EXCESS;
    end
  endfunction

  // advance the parser by one blob byte and queue the result it owes
  function automatic void parse_byte(logic [7:0] b, logic last);
    result_t     r;
    phase_t      ph;
    logic [31:0] nbytes;
    r = '0;
    r.byte_role = ROLE_IGNORED;
    ph = pp_phase;
    if (ph >= PH_VER && ph <= PH_SKIP && pp_body_left > 32'd0) pp_body_left--;

    case (ph)
      PH_IDLE: begin
        r.byte_role = ROLE_HDR;
        if (!b[7]) begin
          pp_err   = ST_BAD_HDR;
          pp_phase = PH_ERR;
        end else if (b[6]) begin
          pp_tag   = {2'b00, b[5:0]};
          pp_phase = PH_NEWLEN;
        end else begin
          pp_tag = {4'd0, b[5:2]};
          if (b[1:0] == OLD_LEN_INDET) begin
            pp_err   = ST_INDET_LEN;
            pp_phase = PH_ERR;
          end else begin
            pp_field_left = (b[1:0] == OLD_LEN_ONE) ? 16'd1 :
                            (b[1:0] == OLD_LEN_TWO) ? 16'd2 : 16'd4;
            pp_acc   = '0;
            pp_phase = PH_MULTI;
          end
        end
      end
      PH_NEWLEN: begin
        r.byte_role = ROLE_LEN;
        if (b < NEW_LEN_TWO_MIN) begin
          close_header({24'd0, b});
        end else if (b < NEW_LEN_PARTIAL) begin
          pp_acc   = {24'd0, b} - 32'd192;
          pp_phase = PH_NEWLEN2;
        end else if (b == NEW_LEN_FIVE) begin
          pp_field_left = 16'd4;
          pp_acc        = '0;
          pp_phase      = PH_MULTI;
        end else begin
          pp_err   = ST_PARTIAL_LEN;
          pp_phase = PH_ERR;
        end
      end
      PH_NEWLEN2: begin
        r.byte_role = ROLE_LEN;
        close_header(((pp_acc & 32'hff) << 8) + {24'd0, b} + 32'd192);
      end
      PH_MULTI: begin
        r.byte_role = ROLE_LEN;
        pp_acc = (pp_acc << 8) | {24'd0, b};
        if (take_count()) close_header(pp_acc);
      end
      PH_VER: begin
        r.byte_role = ROLE_VER;
        if (b != SIG_VERSION) body_fail(ST_BAD_VERSION);
        else pp_phase = PH_TYPE;
      end
      PH_TYPE: begin
        r.byte_role = ROLE_TYPE;
        pp_sig_type = b;
        pp_phase    = PH_PK;
      end
      PH_PK: begin
        r.byte_role = ROLE_PKALGO;
        pp_key_alg  = b;
        pp_phase    = PH_HASH;
      end
      PH_HASH: begin
        r.byte_role = ROLE_HASHALGO;
        pp_dig_alg  = b;
        start_pair(PH_HLEN);
      end
      PH_HLEN: begin
        r.byte_role = ROLE_HLEN;
        if (take_pair(b)) begin
          pp_hlen = pp_acc[15:0];
          if (pp_acc > pp_body_left) body_fail(ST_HASHED_LONG);
          else if (pp_acc == 32'd0) after_hashed();
          else begin
            pp_field_left = pp_acc[15:0];
            pp_phase      = PH_HDATA;
          end
        end
      end
      PH_HDATA: begin
        r.byte_role = ROLE_HDATA;
        if (take_count()) after_hashed();
      end
      PH_ULEN: begin
        r.byte_role = ROLE_ULEN;
        if (take_pair(b)) begin
          pp_ulen = pp_acc[15:0];
          if (pp_acc > pp_body_left) body_fail(ST_UNHASHED_LONG);
          else if (pp_acc == 32'd0) after_unhashed();
          else begin
            pp_field_left = pp_acc[15:0];
            pp_phase      = PH_UDATA;
          end
        end
      end
      PH_UDATA: begin
        r.byte_role = ROLE_UDATA;
        if (take_count()) after_unhashed();
      end
      PH_PREFIX: begin
        r.byte_role = ROLE_PREFIX;
        if (take_pair(b)) begin
          pp_prefix = pp_acc[15:0];
          if (pp_body_left < 32'd2) body_fail(ST_MPI_TRUNC);
          else start_pair(PH_MPILEN);
        end
      end
      PH_MPILEN: begin
        r.byte_role = ROLE_MPILEN;
        if (take_pair(b)) begin
          nbytes      = (pp_acc + 32'd7) / 32'd8;
          pp_mpi_bits = pp_acc[15:0];
          if (nbytes > pp_body_left) body_fail(ST_MPI_LONG);
          else if (nbytes == 32'd0) after_mpi();
          else begin
            pp_field_left = nbytes[15:0];
            pp_phase      = PH_MPI;
          end
        end
      end
      PH_MPI: begin
        r.byte_role = ROLE_MPI;
        if (take_count()) after_mpi();
      end
      PH_EXCESS: r.byte_role = ROLE_EXCESS;
      PH_SKIP:   r.byte_role = ROLE_AFTERERR;
      PH_ERR:    r.byte_role = ROLE_AFTERERR;
      default:   r.byte_role = ROLE_IGNORED;
    endcase

    // body fully consumed: anything further is past the packet
    if (pp_phase >= PH_VER && pp_phase <= PH_SKIP && pp_body_left == 32'd0)
      pp_phase = PH_AFTER;

    r.out_byte = b;
    r.done_res = last;
    if (last) begin
      if (pp_phase == PH_ERR || pp_phase == PH_AFTER) r.status = pp_err;
      else if (pp_phase <= PH_MULTI) r.status = ST_SHORT_HDR;
      else r.status = ST_BODY_EXCEEDS;
      r.signature_type    = pp_sig_type;
      r.key_algorithm     = pp_key_alg;
      r.digest_algorithm  = pp_dig_alg;
      r.digest_prefix     = pp_prefix;
      r.hashed_area_len   = pp_hlen;
      r.unhashed_area_len = pp_ulen;
      r.mpi_bit_count     = pp_mpi_bits;
      clear_parser();
    end
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t result %0d %s: expected %0h got %0h", $time, results_seen, name,
                 want, got);
    end
  endfunction

  // input transfers feed the parser state first, then the result transfer is checked
  always @(posedge clk) begin
    result_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      parse_byte(in_ch.in_byte, in_ch.in_last);
      in_fired = 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected result, byte %0h", $time, out_ch.out_byte);
      end else begin
        want = expected_results.pop_front();
        check_field("byte_role", want.byte_role, out_ch.byte_role);
        check_field("out_byte", want.out_byte, out_ch.out_byte);
        check_field("done_res", want.done_res, out_ch.done_res);
        check_field("status", want.status, out_ch.status);
        check_field("signature_type", want.signature_type, out_ch.signature_type);
        check_field("key_algorithm", want.key_algorithm, out_ch.key_algorithm);
        check_field("digest_algorithm", want.digest_algorithm, out_ch.digest_algorithm);
        check_field("digest_prefix", want.digest_prefix, out_ch.digest_prefix);
        check_field("hashed_area_len", want.hashed_area_len, out_ch.hashed_area_len);
        check_field("unhashed_area_len", want.unhashed_area_len, out_ch.unhashed_area_len);
        check_field("mpi_bit_count", want.mpi_bit_count, out_ch.mpi_bit_count);
      end
      results_seen++;
    end
  end

  // byte driver: a byte stays on the channel until its transfer, gaps only between bytes
  always @(negedge clk) begin
    in_item_t itm;
    if (rst_n) begin
      if (!in_ch.valid || in_fired) begin
        in_fired = 1'b0;
        if (pending_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          itm = pending_bytes.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= itm.in_byte;
          in_ch.in_last <= itm.in_last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic push_blob(input logic [7:0] blob[$]);
    in_item_t itm;
    for (int i = 0; i < blob.size(); i++) begin
      itm.in_byte = blob[i];
      itm.in_last = (i == blob.size() - 1);
      pending_bytes.insert(pending_bytes.size(), itm);
      bytes_queued++;
    end
  endtask

  // sender holds off until the parser has returned every owed result
  task automatic wait_drained();
    do @(negedge clk);
    while (!(pending_bytes.size() == 0 && !in_ch.valid && expected_results.size() == 0));
  endtask

  // one signature packet with random content; some are bent or broken on purpose
  task automatic add_packet();
    logic [7:0]  body[$];
    logic [7:0]  blob[$];
    int unsigned hl, ul, mbits, nb, len, tag, form, wild, v, cut;
    bit          big;
    big   = ($urandom_range(0, 29) == 0);
    tag   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : TAG_SIGNATURE;
    wild  = $urandom_range(0, 14);
    body.insert(body.size(), ($urandom_range(0, 19) == 0) ? 8'($urandom) : SIG_VERSION);
    repeat (3) body.insert(body.size(), 8'($urandom));
    // hashed area
    hl = (wild == 0) ? $urandom_range(0, 65535) :
         big ? $urandom_range(190, 260) : $urandom_range(0, 5);
    body.insert(body.size(), 8'(hl >> 8));
    body.insert(body.size(), 8'(hl));
    if (wild != 0) repeat (hl) body.insert(body.size(), 8'($urandom));
    // unhashed area
    ul = (wild == 1) ? $urandom_range(0, 65535) : $urandom_range(0, 5);
    body.insert(body.size(), 8'(ul >> 8));
    body.insert(body.size(), 8'(ul));
    if (wild != 1) repeat (ul) body.insert(body.size(), 8'($urandom));
    // hash prefix and signature mpi
    repeat (2) body.insert(body.size(), 8'($urandom));
    mbits = (wild == 2) ? $urandom_range(0, 65535) : $urandom_range(0, 48);
    body.insert(body.size(), 8'(mbits >> 8));
    body.insert(body.size(), 8'(mbits));
    nb = (mbits + 7) / 8;
    if (wild != 2) repeat (nb) body.insert(body.size(), 8'($urandom));

    len = body.size();
    case ($urandom_range(0, 9))
      0: len = len + $urandom_range(1, 3);
      1: len = (len > 3) ? len - $urandom_range(1, 3) : len;
      2: if ($urandom_range(0, 3) == 0) len = $urandom;
      default: ;
    endcase

    // header in one of the six length encodings, falling back to the new 5-octet or old four-octet form
    form = $urandom_range(0, 5);
    if (form == 0 && len >= 192) form = 2;
    if (form == 1 && (len < 192 || len > 8383)) form = 2;
    if (form == 3 && len > 255) form = 5;
    if (form == 4 && len > 65535) form = 5;
    if (form >= 3 && tag > 15) form = 2;
    if (form <= 2) blob.insert(blob.size(), 8'(8'hC0 | (tag & 63)));
    else blob.insert(blob.size(), 8'(8'h80 | ((tag & 15) << 2) | (form - 3)));
    case (form)
      0, 3: blob.insert(blob.size(), 8'(len));
      1: begin
        v = len - 192;
        blob.insert(blob.size(), 8'(192 + (v >> 8)));
        blob.insert(blob.size(), 8'(v));
      end
      4: begin
        blob.insert(blob.size(), 8'(len >> 8));
        blob.insert(blob.size(), 8'(len));
      end
      default: begin
        if (form == 2) blob.insert(blob.size(), NEW_LEN_FIVE);
        blob.insert(blob.size(), 8'(len >> 24));
        blob.insert(blob.size(), 8'(len >> 16));
        blob.insert(blob.size(), 8'(len >> 8));
        blob.insert(blob.size(), 8'(len));
      end
    endcase
    for (int i = 0; i < body.size(); i++) blob.insert(blob.size(), body[i]);

    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, blob.size() - 1);
      while (blob.size() > cut) blob.delete(blob.size() - 1);
    end
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) blob.insert(blob.size(), 8'($urandom));
    if ($urandom_range(0, 7) == 0) blob[$urandom_range(0, blob.size() - 1)] = 8'($urandom);
    push_blob(blob);
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input int unsigned budget);
    logic [7:0]  noise[$];
    int unsigned stop_at;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = bytes_queued + budget;
    while (bytes_queued < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        noise.delete();
        repeat ($urandom_range(1, 8)) noise.insert(noise.size(), 8'($urandom));
        push_blob(noise);
      end else begin
        add_packet();
      end
    end
    wait_drained();
  endtask

  initial begin
    logic [7:0] blob[$];
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    in_fired = 1'b0;
    mismatches = 0;
    results_seen = 0;
    bytes_queued = 0;
    src_idle_pct = 9;
    snk_idle_pct = 81;
    clear_parser();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // clear bit 7 in the header byte
    blob = '{8'h00};
    push_blob(blob);
    // old format with indeterminate length
    blob = '{8'h8B};
    push_blob(blob);
    // partial body length
    blob = '{8'hC2, 8'hE0};
    push_blob(blob);
    // blob ends inside the header
    blob = '{8'hC2};
    push_blob(blob);
    // zero-length packet that is not a signature
    blob = '{8'hC6, 8'h00};
    push_blob(blob);
    // body too small, skipped to its end
    blob = '{8'hC2, 8'h02, 8'hAA, 8'h55};
    push_blob(blob);
    // smallest well-formed signature: empty areas, zero-bit mpi
    blob = '{8'hC2, 8'h0C, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
             8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
    push_blob(blob);
    wait_drained();

    run_phase(9, 81, 230);
    run_phase(81, 9, 230);
    run_phase(0, 0, 230);

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
